// ===== design/pcrc_pkg.sv =====
// Shared types, constants and per-stage functions for the point record converter.
// No dependencies; used by point_cloud_record_convert_core and its checker.
package pcrc_pkg;

	localparam int NUM_COORD = 3;
	localparam int DATA_W    = 120;

	// 1e-3 in binary32 is 0x3A83126F: significand with hidden bit below
	localparam logic [23:0] SCALE_SIG = 24'h83126F;

	// sRGB encode of v/255, rounded to a byte
	localparam logic [7:0] GAMMA_LUT [256] = '{
		8'd0,   8'd13,  8'd22,  8'd28,  8'd34,  8'd38,  8'd42,  8'd46,
		8'd50,  8'd53,  8'd56,  8'd59,  8'd61,  8'd64,  8'd66,  8'd69,
		8'd71,  8'd73,  8'd75,  8'd77,  8'd79,  8'd81,  8'd83,  8'd85,
		8'd86,  8'd88,  8'd90,  8'd92,  8'd93,  8'd95,  8'd96,  8'd98,
		8'd99,  8'd101, 8'd102, 8'd104, 8'd105, 8'd106, 8'd108, 8'd109,
		8'd110, 8'd112, 8'd113, 8'd114, 8'd115, 8'd117, 8'd118, 8'd119,
		8'd120, 8'd121, 8'd122, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128,
		8'd129, 8'd130, 8'd131, 8'd132, 8'd133, 8'd134, 8'd135, 8'd136,
		8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd142, 8'd143, 8'd144,
		8'd145, 8'd146, 8'd147, 8'd148, 8'd148, 8'd149, 8'd150, 8'd151,
		8'd152, 8'd153, 8'd154, 8'd155, 8'd155, 8'd156, 8'd157, 8'd158,
		8'd159, 8'd159, 8'd160, 8'd161, 8'd162, 8'd163, 8'd163, 8'd164,
		8'd165, 8'd166, 8'd167, 8'd167, 8'd168, 8'd169, 8'd170, 8'd170,
		8'd171, 8'd172, 8'd173, 8'd173, 8'd174, 8'd175, 8'd175, 8'd176,
		8'd177, 8'd178, 8'd178, 8'd179, 8'd180, 8'd180, 8'd181, 8'd182,
		8'd182, 8'd183, 8'd184, 8'd185, 8'd185, 8'd186, 8'd187, 8'd187,
		8'd188, 8'd189, 8'd189, 8'd190, 8'd190, 8'd191, 8'd192, 8'd192,
		8'd193, 8'd194, 8'd194, 8'd195, 8'd196, 8'd196, 8'd197, 8'd197,
		8'd198, 8'd199, 8'd199, 8'd200, 8'd200, 8'd201, 8'd202, 8'd202,
		8'd203, 8'd203, 8'd204, 8'd205, 8'd205, 8'd206, 8'd206, 8'd207,
		8'd208, 8'd208, 8'd209, 8'd209, 8'd210, 8'd210, 8'd211, 8'd212,
		8'd212, 8'd213, 8'd213, 8'd214, 8'd214, 8'd215, 8'd215, 8'd216,
		8'd216, 8'd217, 8'd218, 8'd218, 8'd219, 8'd219, 8'd220, 8'd220,
		8'd221, 8'd221, 8'd222, 8'd222, 8'd223, 8'd223, 8'd224, 8'd224,
		8'd225, 8'd226, 8'd226, 8'd227, 8'd227, 8'd228, 8'd228, 8'd229,
		8'd229, 8'd230, 8'd230, 8'd231, 8'd231, 8'd232, 8'd232, 8'd233,
		8'd233, 8'd234, 8'd234, 8'd235, 8'd235, 8'd236, 8'd236, 8'd237,
		8'd237, 8'd238, 8'd238, 8'd238, 8'd239, 8'd239, 8'd240, 8'd240,
		8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244, 8'd244,
		8'd245, 8'd245, 8'd246, 8'd246, 8'd246, 8'd247, 8'd247, 8'd248,
		8'd248, 8'd249, 8'd249, 8'd250, 8'd250, 8'd251, 8'd251, 8'd251,
		8'd252, 8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255
	};

	// after the significand multiply
	typedef struct packed {
		logic        sign;
		logic        inf;
		logic [7:0]  e_eff;
		logic [47:0] prod;
	} mul_lane_t;

	// after the alignment shift
	typedef struct packed {
		logic        sign;
		logic        inf;
		logic [7:0]  base;
		logic [24:0] keep;
		logic        rnd;
		logic        sticky;
	} shf_lane_t;

	function automatic logic is_nan(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	function automatic mul_lane_t lane_mul(input logic [31:0] b);
		mul_lane_t r;
		logic [23:0] sig;
		sig     = {(b[30:23] != 8'd0), b[22:0]};
		r.sign  = b[31];
		r.inf   = (b[30:23] == 8'hFF);
		r.e_eff = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		r.prod  = sig * SCALE_SIG;
		return r;
	endfunction

	function automatic shf_lane_t lane_shift(input mul_lane_t l);
		shf_lane_t   r;
		logic [9:0]  be;
		logic [5:0]  sh;
		logic [47:0] t;
		logic [47:0] mask;
		be = {2'b00, l.e_eff} - 10'd10 + {9'd0, l.prod[47]};
		if (!be[9] && be != 10'd0) begin
			sh     = l.prod[47] ? 6'd24 : 6'd23;
			r.base = be[7:0] - 8'd1;
		end else begin
			// result falls below the normal range
			sh     = 6'd34 - l.e_eff[5:0];
			r.base = 8'd0;
		end
		t        = l.prod >> (sh - 6'd1);
		mask     = (48'd1 << (sh - 6'd1)) - 48'd1;
		r.sign   = l.sign;
		r.inf    = l.inf;
		r.rnd    = t[0];
		r.keep   = t[25:1];
		r.sticky = |(l.prod & mask);
		return r;
	endfunction

	function automatic logic [31:0] lane_round(input shf_lane_t l);
		logic [30:0] q;
		logic [30:0] mag;
		q   = {6'd0, l.keep} + {30'd0, l.rnd & (l.sticky | l.keep[0])};
		mag = ({l.base, 23'd0}) + q;
		if (l.inf) begin
			return {l.sign, 8'hFF, 23'd0};
		end
		return {l.sign, mag};
	endfunction

endpackage

// ===== design/point_cloud_record_convert_core.sv =====
// Point record converter: scales three binary32 coordinates by 1e-3 and gamma
// encodes the color in registered stages s1 (multiply), s2 (shift), s3 (round).
// Throughput one beat per cycle; a stage holds while the next is full and held.
// Points with a NaN coordinate are accepted and dropped (no output beat).
// arst_n clears all stage valid bits asynchronously; payload is not reset.
module point_cloud_record_convert_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// x_mm_bits[31:0], y_mm_bits[63:32], z_mm_bits[95:64],
	// red_linear[103:96], green_linear[111:104], blue_linear[119:112]
	input  logic [pcrc_pkg::DATA_W-1:0]  s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// x_m_bits[31:0], y_m_bits[63:32], z_m_bits[95:64], rgb_packed[119:96]
	output logic [pcrc_pkg::DATA_W-1:0]  m_axis_tdata
);
	import pcrc_pkg::*;

	logic      v_s1, v_s2, v_s3;
	logic      adv2, adv3;
	logic      drop;
	mul_lane_t mul_s1 [NUM_COORD];
	logic [23:0] rgb_s1, rgb_s2;
	shf_lane_t shf_s2 [NUM_COORD];
	logic [DATA_W-1:0] out_s3;

	assign adv3          = !v_s3 || m_axis_tready;
	assign adv2          = !v_s2 || adv3;
	assign s_axis_tready = !v_s1 || adv2;
	assign drop          = is_nan(s_axis_tdata[31:0]) || is_nan(s_axis_tdata[63:32]) ||
		is_nan(s_axis_tdata[95:64]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid && !drop;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			for (int i = 0; i < NUM_COORD; i++) begin
				mul_s1[i] <= lane_mul(s_axis_tdata[32*i +: 32]);
			end
			rgb_s1 <= {GAMMA_LUT[s_axis_tdata[103:96]], GAMMA_LUT[s_axis_tdata[111:104]],
				GAMMA_LUT[s_axis_tdata[119:112]]};
		end
		if (adv2) begin
			for (int i = 0; i < NUM_COORD; i++) begin
				shf_s2[i] <= lane_shift(mul_s1[i]);
			end
			rgb_s2 <= rgb_s1;
		end
		if (adv3) begin
			for (int i = 0; i < NUM_COORD; i++) begin
				out_s3[32*i +: 32] <= lane_round(shf_s2[i]);
			end
			out_s3[119:96] <= rgb_s2;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = out_s3;

endmodule

// ===== design/pcrc_checker.sv =====
// Port-level checker for point_cloud_record_convert_core, bound into every instance of it.
// Depends on pcrc_pkg for the data width and the NaN test.
module pcrc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [pcrc_pkg::DATA_W-1:0] s_axis_tdata,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [pcrc_pkg::DATA_W-1:0] m_axis_tdata
);
	import pcrc_pkg::*;

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// a free output side never back-pressures the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled with output ready");

	// NaN points never reach the output
	a_no_nan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !is_nan(m_axis_tdata[31:0]) && !is_nan(m_axis_tdata[63:32]) &&
			!is_nan(m_axis_tdata[95:64]))
		else $error("NaN coordinate on output");

	// an empty output stage leaves room for a new input beat
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output stage empty");

endmodule

bind point_cloud_record_convert_core pcrc_checker u_pcrc_checker (.*);
